// ===== rtl/bbf_pkg.sv =====
// Shared types and constants for the bitmap best-fit allocator.
// Holds the request, result and scan-state structs and the sequencer states.
// Depends on nothing; every other file in rtl refers to it by scoped names.
package bbf_pkg;

  localparam int MAX_UNITS = 1024;
  localparam int WORD_BITS = 8;
  localparam int NUM_WORDS = MAX_UNITS / WORD_BITS;
  localparam int UNIT_W    = $clog2(MAX_UNITS);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int ADDR_W    = UNIT_W - BIT_W;
  localparam int CNT_W     = 11;
  localparam int LEN_W     = UNIT_W + 1;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_QUERY   = 2'd2
  } command_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [UNIT_W-1:0] index;
    logic [CNT_W-1:0]  count;
  } request_t;

  typedef struct packed {
    logic              status;
    logic [UNIT_W-1:0] start_res;
    logic              bit_value;
  } result_t;

  typedef struct packed {
    logic              in_run;
    logic [UNIT_W-1:0] run_start;
    logic [LEN_W-1:0]  run_len;
    logic              found;
    logic [UNIT_W-1:0] best_start;
    logic [LEN_W-1:0]  best_len;
  } scan_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN,
    ST_CLOSE,
    ST_MOD_RD,
    ST_MOD,
    ST_QUERY_RD,
    ST_QUERY
  } state_t;

endpackage

// ===== rtl/bbf_map_mem.sv =====
// Allocation map storage: one word of bbf_pkg::WORD_BITS units per address.
// One write port and one registered read port; a per-word valid bit makes
// every word read as free after reset. Depends on bbf_pkg.
module bbf_map_mem (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       we,
  input  logic [bbf_pkg::ADDR_W-1:0] waddr,
  input  bbf_pkg::word_t             wdata,
  input  logic [bbf_pkg::ADDR_W-1:0] raddr,
  output bbf_pkg::word_t             rdata
);

  bbf_pkg::word_t                  mem [bbf_pkg::NUM_WORDS];
  logic [bbf_pkg::NUM_WORDS-1:0]   valid;
  bbf_pkg::word_t                  rdata_q;
  logic                            rvalid_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      rvalid_q <= valid[raddr];
    end
  end

  assign rdata = rvalid_q ? rdata_q : '0;

endmodule

// ===== rtl/bbf_run_scan.sv =====
// Shared run-length unit: folds one map word into the running free-run and
// best-fit state. Units at or beyond the pool size count as allocated.
// Depends on bbf_pkg.
module bbf_run_scan (
  input  bbf_pkg::word_t                bits,
  input  logic [bbf_pkg::ADDR_W-1:0]    base,
  input  logic [bbf_pkg::CNT_W-1:0]     size,
  input  logic [bbf_pkg::CNT_W-1:0]     count,
  input  bbf_pkg::scan_state_t          cur,
  output bbf_pkg::scan_state_t          nxt
);

  always_comb begin
    bbf_pkg::scan_state_t      s;
    logic [bbf_pkg::UNIT_W-1:0] pos;
    logic                       free;
    s = cur;
    for (int j = 0; j < bbf_pkg::WORD_BITS; j++) begin
      pos  = {base, bbf_pkg::BIT_W'(j)};
      free = !bits[j] && ({1'b0, pos} < size);
      if (free) begin
        if (!s.in_run) begin
          s.in_run    = 1'b1;
          s.run_start = pos;
          s.run_len   = bbf_pkg::LEN_W'(1);
        end else begin
          s.run_len = s.run_len + 1'b1;
        end
      end else if (s.in_run) begin
        if ((s.run_len >= count) && (!s.found || (s.run_len < s.best_len))) begin
          s.found      = 1'b1;
          s.best_start = s.run_start;
          s.best_len   = s.run_len;
        end
        s.in_run = 1'b0;
      end
    end
    nxt = s;
  end

endmodule

// ===== rtl/bitmap_best_fit_allocator.sv =====
// Top level of the bitmap best-fit allocator: command sequencer, map memory
// and the shared run-length unit. Depends on bbf_pkg, bbf_map_mem and
// bbf_run_scan.
//
// A transaction is accepted when start is high and busy is low; req carries
// command, index and count. Each transaction returns exactly one result,
// shown on result for one cycle with result_valid high; the receiver cannot
// stall it. busy stays high while a transaction is in progress.
// Allocate reads the map one 8-unit word per cycle, then marks the chosen
// run word by word. Release clears its range word by word; query reads the
// one word that holds the index. A zero-count allocate, an empty release and
// an unknown command answer straight from idle. The map word port allows one
// read and one write a cycle.
// cfg_we writes pool_size from cfg_data; write it only while idle.
// Reset clears the whole map at once through per-word valid bits and sets
// pool_size to 1024; the block is ready in the cycle after reset.
module bitmap_best_fit_allocator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  bbf_pkg::request_t          req,
  output logic                       result_valid,
  output bbf_pkg::result_t           result,
  input  logic                       cfg_we,
  input  logic [bbf_pkg::CNT_W-1:0]  cfg_data
);

  localparam logic [bbf_pkg::CNT_W-1:0] MAX_SIZE = bbf_pkg::CNT_W'(bbf_pkg::MAX_UNITS);

  bbf_pkg::state_t               state, state_next;
  logic [1:0]                    cmd_q, cmd_next;
  logic [bbf_pkg::UNIT_W-1:0]    idx_q, idx_next;
  logic [bbf_pkg::CNT_W-1:0]     cnt_q, cnt_next;
  logic [bbf_pkg::CNT_W-1:0]     size_q, size_next;
  logic [bbf_pkg::ADDR_W-1:0]    word, word_next;
  logic [bbf_pkg::ADDR_W-1:0]    last_word, last_word_next;
  logic [bbf_pkg::UNIT_W-1:0]    lo, lo_next;
  logic [bbf_pkg::CNT_W-1:0]     hi, hi_next;
  logic                          set_mode, set_mode_next;
  bbf_pkg::scan_state_t          scan_st, scan_next, scan_out;
  logic [bbf_pkg::CNT_W-1:0]     pool_size;
  bbf_pkg::result_t              result_next;
  logic                          result_valid_next;

  logic [bbf_pkg::CNT_W-1:0]     act_size, act_size_m1;
  logic [bbf_pkg::CNT_W:0]       rel_end;
  logic [bbf_pkg::CNT_W-1:0]     rel_hi, rel_hi_m1;
  logic [bbf_pkg::CNT_W-1:0]     alloc_end, alloc_end_m1;
  bbf_pkg::word_t                rdata, wdata, mask, scan_bits;
  logic [bbf_pkg::ADDR_W-1:0]    raddr;
  logic                          mem_we;

  assign busy        = (state != bbf_pkg::ST_IDLE);
  assign act_size    = (pool_size > MAX_SIZE) ? MAX_SIZE : pool_size;
  assign act_size_m1 = act_size - 1'b1;
  assign rel_end     = {2'b00, req.index} + {1'b0, req.count};
  assign rel_hi      = (rel_end > {1'b0, act_size}) ? act_size : rel_end[bbf_pkg::CNT_W-1:0];
  assign rel_hi_m1   = rel_hi - 1'b1;
  assign alloc_end   = {1'b0, scan_out.best_start} + cnt_q;
  assign alloc_end_m1 = alloc_end - 1'b1;
  assign scan_bits   = (state == bbf_pkg::ST_CLOSE) ? '1 : rdata;

  always_comb begin
    logic [bbf_pkg::UNIT_W-1:0] pos;
    for (int j = 0; j < bbf_pkg::WORD_BITS; j++) begin
      pos     = {word, bbf_pkg::BIT_W'(j)};
      mask[j] = (pos >= lo) && ({1'b0, pos} < hi);
    end
  end

  assign wdata = set_mode ? (rdata | mask) : (rdata & ~mask);

  bbf_map_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (word),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  bbf_run_scan u_scan (
    .bits  (scan_bits),
    .base  (word),
    .size  (size_q),
    .count (cnt_q),
    .cur   (scan_st),
    .nxt   (scan_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= bbf_pkg::ST_IDLE;
      result_valid <= 1'b0;
      pool_size    <= MAX_SIZE;
      scan_st      <= '0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
      scan_st      <= scan_next;
      if (cfg_we) begin
        pool_size <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_q     <= cmd_next;
    idx_q     <= idx_next;
    cnt_q     <= cnt_next;
    size_q    <= size_next;
    word      <= word_next;
    last_word <= last_word_next;
    lo        <= lo_next;
    hi        <= hi_next;
    set_mode  <= set_mode_next;
    result    <= result_next;
  end

  always_comb begin
    state_next        = state;
    cmd_next          = cmd_q;
    idx_next          = idx_q;
    cnt_next          = cnt_q;
    size_next         = size_q;
    word_next         = word;
    last_word_next    = last_word;
    lo_next           = lo;
    hi_next           = hi;
    set_mode_next     = set_mode;
    scan_next         = scan_st;
    result_next       = result;
    result_valid_next = 1'b0;
    mem_we            = 1'b0;
    raddr             = word;
    case (state)
      bbf_pkg::ST_IDLE: begin
        if (start) begin
          cmd_next  = req.command;
          idx_next  = req.index;
          cnt_next  = req.count;
          size_next = act_size;
          scan_next = '0;
          word_next = '0;
          result_next = '0;
          case (req.command)
            bbf_pkg::CMD_ALLOC: begin
              if (req.count == '0) begin
                result_next.status = 1'b1;
                result_valid_next  = 1'b1;
              end else if (act_size == '0) begin
                state_next = bbf_pkg::ST_CLOSE;
              end else begin
                last_word_next = act_size_m1[bbf_pkg::UNIT_W-1:bbf_pkg::BIT_W];
                state_next     = bbf_pkg::ST_SCAN_RD;
              end
            end
            bbf_pkg::CMD_RELEASE: begin
              if ({1'b0, req.index} >= rel_hi) begin
                result_valid_next = 1'b1;
              end else begin
                lo_next        = req.index;
                hi_next        = rel_hi;
                set_mode_next  = 1'b0;
                word_next      = req.index[bbf_pkg::UNIT_W-1:bbf_pkg::BIT_W];
                last_word_next = rel_hi_m1[bbf_pkg::UNIT_W-1:bbf_pkg::BIT_W];
                state_next     = bbf_pkg::ST_MOD_RD;
              end
            end
            bbf_pkg::CMD_QUERY: begin
              word_next  = req.index[bbf_pkg::UNIT_W-1:bbf_pkg::BIT_W];
              state_next = bbf_pkg::ST_QUERY_RD;
            end
            default: begin
              result_valid_next = 1'b1;
            end
          endcase
        end
      end
      bbf_pkg::ST_SCAN_RD: begin
        state_next = bbf_pkg::ST_SCAN;
      end
      bbf_pkg::ST_SCAN: begin
        raddr     = word + 1'b1;
        scan_next = scan_out;
        if (word == last_word) begin
          state_next = bbf_pkg::ST_CLOSE;
        end else begin
          word_next = word + 1'b1;
        end
      end
      bbf_pkg::ST_CLOSE: begin
        scan_next = scan_out;
        if (scan_out.found) begin
          lo_next        = scan_out.best_start;
          hi_next        = alloc_end;
          set_mode_next  = 1'b1;
          word_next      = scan_out.best_start[bbf_pkg::UNIT_W-1:bbf_pkg::BIT_W];
          last_word_next = alloc_end_m1[bbf_pkg::UNIT_W-1:bbf_pkg::BIT_W];
          state_next     = bbf_pkg::ST_MOD_RD;
        end else begin
          result_next        = '0;
          result_next.status = 1'b1;
          result_valid_next  = 1'b1;
          state_next         = bbf_pkg::ST_IDLE;
        end
      end
      bbf_pkg::ST_MOD_RD: begin
        state_next = bbf_pkg::ST_MOD;
      end
      bbf_pkg::ST_MOD: begin
        raddr  = word + 1'b1;
        mem_we = 1'b1;
        if (word == last_word) begin
          result_next = '0;
          if (cmd_q == bbf_pkg::CMD_ALLOC) begin
            result_next.start_res = lo;
          end
          result_valid_next = 1'b1;
          state_next        = bbf_pkg::ST_IDLE;
        end else begin
          word_next = word + 1'b1;
        end
      end
      bbf_pkg::ST_QUERY_RD: begin
        state_next = bbf_pkg::ST_QUERY;
      end
      bbf_pkg::ST_QUERY: begin
        result_next = '0;
        if ({1'b0, idx_q} < size_q) begin
          result_next.bit_value = rdata[idx_q[bbf_pkg::BIT_W-1:0]];
        end
        result_valid_next = 1'b1;
        state_next        = bbf_pkg::ST_IDLE;
      end
      default: begin
        state_next = bbf_pkg::ST_IDLE;
      end
    endcase
  end

  // A result always closes its transaction, so the block is ready with it.
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy)
    else $error("result shown while busy");

  // The best run found so far always holds the requested count.
  a_best_fits: assert property (@(posedge clk) disable iff (rst)
    scan_st.found |-> (scan_st.best_len >= cnt_q))
    else $error("best run shorter than count");

  // Only an allocation sets bits in the map.
  a_set_alloc: assert property (@(posedge clk) disable iff (rst)
    (mem_we && set_mode) |-> (cmd_q == bbf_pkg::CMD_ALLOC))
    else $error("map bits set outside an allocation");

  // A granted run lies inside the active pool.
  a_run_in_pool: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (cmd_q == bbf_pkg::CMD_ALLOC) && !result.status) |->
      (({2'b00, result.start_res} + {1'b0, cnt_q}) <= {1'b0, size_q}))
    else $error("granted run exceeds pool");

endmodule
